// File: design/shelf_atlas_placer_macros.svh
// Assertion macros for the checker file of the shelf placer.
`ifndef SHELF_ATLAS_PLACER_MACROS_SVH
`define SHELF_ATLAS_PLACER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SAP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SAP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sap_pkg.sv
package sap_pkg;

    // Default sizes.
    localparam int SAP_MAX_ENTRIES  = 256;
    localparam int SAP_MAX_RECT_DIM = 4096;

    // Field widths.
    localparam int KIND_W     = 2;
    localparam int DIM_W      = 13;
    localparam int CHAN_W     = 3;
    localparam int IDX_W      = 8;
    localparam int COORD_W    = 17;
    localparam int ERR_W      = 3;
    localparam int POSX_W     = 15;
    localparam int POSY_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // Map arithmetic: Q1.16 coordinates, 33-bit dividend, 17-bit quotient.
    localparam int FRAC_W = 16;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 16;
    localparam int QUOT_W = 17;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Result codes.
    localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_CHANNEL = 3'd1;
    localparam logic [ERR_W-1:0] ERR_INDEX   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_FULL    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_HEIGHT  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

    // Configuration reset values.
    localparam logic [POSX_W-1:0] RST_MAX_ROW_WIDTH = 15'd4096;
    localparam logic [CHAN_W-1:0] RST_CHANNEL_COUNT = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SUM,
        ST_START,
        ST_WAIT,
        ST_DONE
    } t_state;

    // One placed rectangle: atlas offset and size.
    typedef struct packed {
        logic [POSX_W-1:0] ox;
        logic [POSY_W-1:0] oy;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
    } t_entry;

    // Divider status toward the controller.
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

// File: design/sap_entry_ram.sv
module sap_entry_ram #(
    parameter int DEPTH = sap_pkg::SAP_MAX_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  sap_pkg::t_entry          i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output sap_pkg::t_entry          o_rdata
);
    import sap_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sap_divider.sv
module sap_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sap_pkg::NUM_W-1:0]    i_num,
    input  logic [sap_pkg::DEN_W-1:0]    i_den,
    output sap_pkg::t_div_res            o_res
);
    import sap_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic              w_sat;

    // The quotient only fits when the upper dividend bits stay below the divisor.
    assign w_sat   = i_num[NUM_W-1:QUOT_W] >= i_den;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign w_trial = {r_rem, r_low[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    // Control: busy while stepping, done once the quotient stands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !w_sat;
            r_done <= w_sat;
            r_cnt  <= CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Datapath: remainder, remaining dividend bits and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[NUM_W-1:QUOT_W];
            r_low  <= i_num[QUOT_W-1:0];
            r_den  <= i_den;
            r_quot <= w_sat ? '1 : '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

// File: design/shelf_atlas_placer.sv
// Channel   Direction  Handshake           Contents
// request   in         i_valid / o_ready   kind, rectangle size, channels, index, u, v
// result    out        o_valid / i_ready   code, index, offset, totals, mapped u, v
// config    in         i_cfg_we            register index and data, no wait
//
// Append and clear go through the execute and done states to the output register.
// Map: read, sum, start, wait; the 17-step serial dividers for u and v run side by side.
// One request is in flight at a time; the next is taken once the result is registered,
// while the previous result may still wait in the output register.
// Reset is synchronous, active low. The entry memory needs no clearing pass:
// entries at or above the entry count may be read but never reach a result.
module shelf_atlas_placer #(
    parameter int MAX_ENTRIES = sap_pkg::SAP_MAX_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel.
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [sap_pkg::KIND_W-1:0]      i_kind,
    input  logic [sap_pkg::DIM_W-1:0]       i_rect_width,
    input  logic [sap_pkg::DIM_W-1:0]       i_rect_height,
    input  logic [sap_pkg::CHAN_W-1:0]      i_rect_channels,
    input  logic [sap_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [sap_pkg::COORD_W-1:0]     i_tex_u,
    input  logic [sap_pkg::COORD_W-1:0]     i_tex_v,
    // Result channel.
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [sap_pkg::ERR_W-1:0]       o_error_code,
    output logic [sap_pkg::IDX_W-1:0]       o_placed_index,
    output logic [sap_pkg::POSX_W-1:0]      o_offset_x,
    output logic [sap_pkg::POSY_W-1:0]      o_offset_y,
    output logic [sap_pkg::POSX_W-1:0]      o_total_width,
    output logic [sap_pkg::POSY_W-1:0]      o_total_height,
    output logic [sap_pkg::COORD_W-1:0]     o_atlas_u,
    output logic [sap_pkg::COORD_W-1:0]     o_atlas_v,
    // Configuration port.
    input  logic                            i_cfg_we,
    input  logic [sap_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sap_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sap_pkg::*;

    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CW > IDX_W) ? CW : IDX_W;
    localparam int PROD_W = COORD_W + DIM_W;

    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [IDX_W-1:0]   pidx;
        logic [POSX_W-1:0]  ox;
        logic [POSY_W-1:0]  oy;
        logic [COORD_W-1:0] au;
        logic [COORD_W-1:0] av;
    } t_result;

    t_state r_state;
    t_state n_state;

    // Configuration and packer state.
    logic [POSX_W-1:0] r_max_row_width;
    logic [CHAN_W-1:0] r_channel_count;
    logic [POSX_W-1:0] r_cursor_x;
    logic [POSY_W-1:0] r_cursor_y;
    logic [DIM_W-1:0]  r_row_height;
    logic [POSX_W-1:0] r_atlas_width;
    logic [POSY_W-1:0] r_atlas_height;
    logic [CW-1:0]     r_entry_count;

    // Request held for the duration of its work.
    logic [KIND_W-1:0]  r_kind;
    logic [DIM_W-1:0]   r_w;
    logic [DIM_W-1:0]   r_h;
    logic [CHAN_W-1:0]  r_ch;
    logic [IDX_W-1:0]   r_idx;
    logic [COORD_W-1:0] r_tu;
    logic [COORD_W-1:0] r_tv;

    // Map datapath.
    logic [PROD_W-1:0] r_prod_u;
    logic [PROD_W-1:0] r_prod_v;
    logic [POSX_W-1:0] r_off_u;
    logic [POSY_W-1:0] r_off_v;
    logic [NUM_W-1:0]  r_num_u;
    logic [NUM_W-1:0]  r_num_v;

    // Staged result and output register.
    t_result            r_res;
    logic               r_out_valid;
    logic [ERR_W-1:0]   r_out_err;
    logic [IDX_W-1:0]   r_out_pidx;
    logic [POSX_W-1:0]  r_out_ox;
    logic [POSY_W-1:0]  r_out_oy;
    logic [POSX_W-1:0]  r_out_tw;
    logic [POSY_W-1:0]  r_out_th;
    logic [COORD_W-1:0] r_out_au;
    logic [COORD_W-1:0] r_out_av;

    // Control strobes.
    logic     w_ram_re;
    logic     w_ram_we;
    logic     w_div_start;
    logic     w_out_load;
    t_entry   w_rd_entry;
    t_entry   w_wr_entry;
    t_div_res w_div_u;
    t_div_res w_div_v;

    // Placement arithmetic.
    logic [POSX_W:0]   w_sum_x;
    logic              w_wrap;
    logic [POSX_W-1:0] w_nx;
    logic [POSY_W-1:0] w_ny;
    logic [DIM_W-1:0]  w_nr0;
    logic [DIM_W-1:0]  w_nr;
    logic [POSY_W:0]   w_bottom;
    logic [POSX_W:0]   w_new_x;
    logic              w_dim_err;
    logic [ERR_W-1:0]  w_app_code;
    logic              w_map_err;

    // Candidate position: the current row, or a new row at the bottom of the atlas.
    // The atlas height always equals the row start plus the row height.
    assign w_sum_x   = (POSX_W+1)'(r_cursor_x) + (POSX_W+1)'(r_w);
    assign w_wrap    = w_sum_x > (POSX_W+1)'(r_max_row_width);
    assign w_nx      = w_wrap ? '0 : r_cursor_x;
    assign w_ny      = w_wrap ? r_atlas_height : r_cursor_y;
    assign w_nr0     = w_wrap ? '0 : r_row_height;
    assign w_nr      = (r_h > w_nr0) ? r_h : w_nr0;
    assign w_bottom  = (POSY_W+1)'(w_ny) + (POSY_W+1)'(w_nr);
    assign w_new_x   = (POSX_W+1)'(w_nx) + (POSX_W+1)'(r_w);
    assign w_dim_err = (32'(r_w) > 32'(SAP_MAX_RECT_DIM)) ||
                       (32'(r_h) > 32'(SAP_MAX_RECT_DIM));

    // Append checks in priority order.
    always_comb begin
        if (r_ch != r_channel_count) begin
            w_app_code = ERR_CHANNEL;
        end else if (r_entry_count >= CW'(MAX_ENTRIES)) begin
            w_app_code = ERR_FULL;
        end else if (w_dim_err || w_bottom[POSY_W]) begin
            w_app_code = ERR_HEIGHT;
        end else begin
            w_app_code = ERR_OK;
        end
    end

    // Map checks: index beyond the table fill or an empty atlas.
    assign w_map_err = (CMP_W'(r_idx) >= CMP_W'(r_entry_count)) ||
                       (r_atlas_width == '0) || (r_atlas_height == '0);

    assign w_wr_entry.ox = w_nx;
    assign w_wr_entry.oy = w_ny;
    assign w_wr_entry.w  = r_w;
    assign w_wr_entry.h  = r_h;

    // Entry table. Reads and writes never overlap: one request runs at a time.
    sap_entry_ram #(
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(r_entry_count)),
        .i_wdata (w_wr_entry),
        .i_re    (w_ram_re),
        .i_raddr (AW'(i_entry_index)),
        .o_rdata (w_rd_entry)
    );

    // Dividers for the two axes.
    sap_divider u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num_u),
        .i_den   (DEN_W'(r_atlas_width)),
        .o_res   (w_div_u)
    );

    sap_divider u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num_v),
        .i_den   (DEN_W'(r_atlas_height)),
        .o_res   (w_div_v)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes.
    always_comb begin
        n_state     = r_state;
        w_ram_re    = 1'b0;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        KIND_APPEND, KIND_CLEAR: n_state = ST_EXEC;
                        KIND_MAP: begin
                            n_state  = ST_READ;
                            w_ram_re = 1'b1;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: begin
                n_state  = ST_DONE;
                w_ram_we = (r_kind == KIND_APPEND) && (w_app_code == ERR_OK);
            end
            ST_READ: begin
                n_state = w_map_err ? ST_DONE : ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_START;
            end
            ST_START: begin
                w_div_start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_div_u.done && w_div_v.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    // Configuration registers and packer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_row_width <= RST_MAX_ROW_WIDTH;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_cursor_x      <= '0;
            r_cursor_y      <= '0;
            r_row_height    <= '0;
            r_atlas_width   <= '0;
            r_atlas_height  <= '0;
            r_entry_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_ROW_WIDTH: r_max_row_width <= i_cfg_data[POSX_W-1:0];
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_EXEC && r_kind == KIND_CLEAR) begin
                r_cursor_x     <= '0;
                r_cursor_y     <= '0;
                r_row_height   <= '0;
                r_atlas_width  <= '0;
                r_atlas_height <= '0;
                r_entry_count  <= '0;
            end else if (w_ram_we) begin
                r_cursor_x     <= w_new_x[POSX_W-1:0];
                r_cursor_y     <= w_ny;
                r_row_height   <= w_nr;
                r_atlas_height <= w_bottom[POSY_W-1:0];
                r_entry_count  <= r_entry_count + CW'(1);
                if (w_new_x[POSX_W-1:0] > r_atlas_width) begin
                    r_atlas_width <= w_new_x[POSX_W-1:0];
                end
            end
        end
    end

    // Request capture and the work of each state.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_kind <= i_kind;
            r_w    <= i_rect_width;
            r_h    <= i_rect_height;
            r_ch   <= i_rect_channels;
            r_idx  <= i_entry_index;
            r_tu   <= i_tex_u;
            r_tv   <= i_tex_v;
        end
        case (r_state)
            ST_EXEC: begin
                if (r_kind == KIND_APPEND && w_app_code == ERR_OK) begin
                    r_res <= '{err: ERR_OK, pidx: IDX_W'(r_entry_count), ox: w_nx, oy: w_ny,
                               default: '0};
                end else if (r_kind == KIND_APPEND) begin
                    r_res <= '{err: w_app_code, default: '0};
                end else begin
                    r_res <= '0;
                end
            end
            ST_READ: begin
                r_prod_u <= PROD_W'(r_tu) * PROD_W'(w_rd_entry.w);
                r_prod_v <= PROD_W'(r_tv) * PROD_W'(w_rd_entry.h);
                r_off_u  <= w_rd_entry.ox;
                r_off_v  <= w_rd_entry.oy;
                r_res    <= '{err: (w_map_err ? ERR_INDEX : ERR_OK), default: '0};
            end
            ST_SUM: begin
                r_num_u <= NUM_W'({r_off_u, {FRAC_W{1'b0}}}) + NUM_W'(r_prod_u);
                r_num_v <= NUM_W'({r_off_v, {FRAC_W{1'b0}}}) + NUM_W'(r_prod_v);
            end
            ST_WAIT: begin
                // Only a map that passed its checks gets here.
                r_res <= '{err: ERR_OK, au: w_div_u.quot, av: w_div_v.quot, default: '0};
            end
            default: ;
        endcase
    end

    // Output register: the next request may start while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_err  <= r_res.err;
            r_out_pidx <= r_res.pidx;
            r_out_ox   <= r_res.ox;
            r_out_oy   <= r_res.oy;
            r_out_tw   <= r_atlas_width;
            r_out_th   <= r_atlas_height;
            r_out_au   <= r_res.au;
            r_out_av   <= r_res.av;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_error_code   = r_out_err;
    assign o_placed_index = r_out_pidx;
    assign o_offset_x     = r_out_ox;
    assign o_offset_y     = r_out_oy;
    assign o_total_width  = r_out_tw;
    assign o_total_height = r_out_th;
    assign o_atlas_u      = r_out_au;
    assign o_atlas_v      = r_out_av;

endmodule

// File: design/sap_checker.sv
`include "shelf_atlas_placer_macros.svh"

module sap_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [sap_pkg::KIND_W-1:0]  i_kind,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [sap_pkg::ERR_W-1:0]   o_error_code,
    input logic [sap_pkg::IDX_W-1:0]   o_placed_index,
    input logic [sap_pkg::POSX_W-1:0]  o_offset_x,
    input logic [sap_pkg::POSY_W-1:0]  o_offset_y,
    input logic [sap_pkg::COORD_W-1:0] o_atlas_u,
    input logic [sap_pkg::COORD_W-1:0] o_atlas_v
);
    import sap_pkg::*;

    // A result that is not taken stays offered.
    `SAP_ASSERT_NXT(a_result_holds, o_valid && !i_ready, o_valid, "result dropped while stalled")

    // A real request occupies the block, so no request is taken in the next cycle.
    `SAP_ASSERT_NXT(a_one_in_flight, i_valid && o_ready && (i_kind == KIND_APPEND || i_kind == KIND_MAP || i_kind == KIND_CLEAR), !o_ready, "second request taken while busy")

    // A fresh result comes out of a busy period, never straight from idle.
    `SAP_ASSERT_IMP(a_result_after_work, $rose(o_valid), !$past(o_ready), "result appeared without work")

    // A failed request carries no placement and no mapped coordinate.
    `SAP_ASSERT_IMP(a_error_zero_fields, o_valid && o_error_code != ERR_OK, o_placed_index == 0 && o_offset_x == 0 && o_offset_y == 0 && o_atlas_u == 0 && o_atlas_v == 0, "error result with nonzero fields")

endmodule

bind shelf_atlas_placer sap_checker u_sap_checker (.*);
